// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, command and status codes and entry type for the sorted
// priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int VAL_W  = 8;
  localparam int PRI_W  = 8;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SHOW    = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_ENTRY = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;
  } entry_t;

  // Circular buffer index step with wrap at DEPTH
  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
    inc_idx = (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + IDX_W'(1));
  endfunction

  function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] i);
    dec_idx = (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - IDX_W'(1));
  endfunction

endpackage

// ----- rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channel interfaces for the command input and the result output.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VAL_W-1:0] item_value;
  logic [PRI_W-1:0] item_priority;

  modport source (output valid, cmd, item_value, item_priority, input ready);
  modport sink   (input valid, cmd, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  out_value;
  logic [PRI_W-1:0]  out_priority;
  logic              last;

  modport source (output valid, status, out_value, out_priority, last, input ready);
  modport sink   (input valid, status, out_value, out_priority, last, output ready);
endinterface

// ----- rtl/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted priority queue of up to DEPTH value/priority pairs kept in a circular
// buffer memory, ordered by ascending priority number, ties in arrival order.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake         Payload
//  --------  ---  ----------------  --------------------------------------------
//  in_ch     in   valid/ready       cmd, item_value, item_priority
//  out_ch    out  valid/ready       status, out_value, out_priority, last
//
//  Insert walks the buffer from the tail with the single compare unit, one
//  memory read and one write per cycle, shifting each entry with a larger
//  priority number one slot toward the tail. Peek and show of an empty queue
//  return no result.
//  Reset: rst_n is synchronous and active low; the queue comes up empty.
//  Stalls: a new command is taken only when idle and the result register is
//  free or draining; show holds its scan while out_ch is stalled.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;  // take commands
  localparam logic [1:0] ST_INS  = 2'd1;  // compare and shift toward tail
  localparam logic [1:0] ST_PUT  = 2'd2;  // drop new pair into head slot
  localparam logic [1:0] ST_SHOW = 2'd3;  // stream entries from head

  // Entry storage: circular buffer, one write and one registered read a cycle
  entry_t mem [DEPTH];

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;   // address of the entry held in q_r
  logic [CNT_W-1:0]  left_r, left_nxt;   // entries still to visit, current one included
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [PRI_W-1:0]  pri_r, pri_nxt;
  entry_t            q_r;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [PRI_W-1:0]  out_prio_r, out_prio_nxt;
  logic              out_last_r, out_last_nxt;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            new_entry;
  logic              out_free;
  logic              in_ready;
  logic              in_xfer;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_xfer   = in_ready && in_ch.valid;
  assign new_entry = '{value: val_r, prio: pri_r};

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    left_nxt       = left_r;
    val_nxt        = val_r;
    pri_nxt        = pri_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_prio_nxt   = out_prio_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    we             = 1'b0;
    wr_addr        = tail_r;
    wr_data        = q_r;

    // Drop the result once its transfer completes; a load below overrides
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          val_nxt = in_ch.item_value;
          pri_nxt = in_ch.item_priority;
          case (in_ch.cmd)
            CMD_INSERT: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                // Full: drop the pair, report it
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_FULL;
                out_value_nxt  = '0;
                out_prio_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else if (cnt_r == '0) begin
                we       = 1'b1;
                wr_addr  = tail_r;
                wr_data  = '{value: in_ch.item_value, prio: in_ch.item_priority};
                tail_nxt = inc_idx(tail_r);
                cnt_nxt  = CNT_W'(cnt_r + CNT_W'(1));
              end else begin
                // Start the scan at the tail entry
                rd_en     = 1'b1;
                rd_addr   = dec_idx(tail_r);
                scan_nxt  = dec_idx(tail_r);
                left_nxt  = cnt_r;
                state_nxt = ST_INS;
              end
            end
            CMD_DEQUEUE: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
                out_value_nxt  = '0;
                out_prio_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                head_nxt = inc_idx(head_r);
                cnt_nxt  = CNT_W'(cnt_r - CNT_W'(1));
              end
            end
            CMD_PEEK: begin
              if (cnt_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                scan_nxt  = head_r;
                left_nxt  = CNT_W'(1);
                state_nxt = ST_SHOW;
              end
            end
            default: begin
              if (cnt_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                scan_nxt  = head_r;
                left_nxt  = cnt_r;
                state_nxt = ST_SHOW;
              end
            end
          endcase
        end
      end

      ST_INS: begin
        we      = 1'b1;
        wr_addr = inc_idx(scan_r);
        if (q_r.prio > pri_r) begin
          // Shift this entry one slot toward the tail
          wr_data = q_r;
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = dec_idx(scan_r);
            scan_nxt = dec_idx(scan_r);
            left_nxt = CNT_W'(left_r - CNT_W'(1));
          end
        end else begin
          // Equal or lower number stays ahead: new pair goes right behind it
          wr_data   = new_entry;
          tail_nxt  = inc_idx(tail_r);
          cnt_nxt   = CNT_W'(cnt_r + CNT_W'(1));
          state_nxt = ST_IDLE;
        end
      end

      ST_PUT: begin
        we        = 1'b1;
        wr_addr   = scan_r;
        wr_data   = new_entry;
        tail_nxt  = inc_idx(tail_r);
        cnt_nxt   = CNT_W'(cnt_r + CNT_W'(1));
        state_nxt = ST_IDLE;
      end

      ST_SHOW: begin
        // Hold the read data while the result register is stalled
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_ENTRY;
          out_value_nxt  = q_r.value;
          out_prio_nxt   = q_r.prio;
          out_last_nxt   = (left_r == CNT_W'(1));
          if (left_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = inc_idx(scan_r);
            scan_nxt = inc_idx(scan_r);
            left_nxt = CNT_W'(left_r - CNT_W'(1));
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    left_r       <= left_nxt;
    val_r        <= val_nxt;
    pri_r        <= pri_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_prio_r   <= out_prio_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_value    = out_value_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.last         = out_last_r;

  // Expected tail from head and fill count, for the consistency check
  logic [CNT_W:0]   chk_sum;
  logic [IDX_W-1:0] chk_tail;

  assign chk_sum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(cnt_r);
  assign chk_tail = (chk_sum >= (CNT_W + 1)'(DEPTH)) ?
                    IDX_W'(chk_sum - (CNT_W + 1)'(DEPTH)) : IDX_W'(chk_sum);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == chk_tail)
    else $error("tail pointer out of step with head and count");

  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS || state_r == ST_SHOW) |-> left_r != '0)
    else $error("scan running with no entries left");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == CMD_DEQUEUE && cnt_r != '0)
      |=> cnt_r == CNT_W'($past(cnt_r) - CNT_W'(1)))
    else $error("dequeue did not remove the head");

endmodule
